/* rtl/dss_pkg.sv */
// debounced save scheduler package: command codes, register indexes,
// reset constants and the structs shared by the core and the top level
// no dependencies
package dss_pkg;

  localparam int CmdW     = 2;
  localparam int DelayW   = 12;
  localparam int TimeW    = 32;
  localparam int SeqW     = 32;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 32;

  localparam logic [CmdW-1:0] CmdSetDelay = 2'd0;
  localparam logic [CmdW-1:0] CmdTick     = 2'd1;
  localparam logic [CmdW-1:0] CmdSaveDone = 2'd2;
  localparam logic [CmdW-1:0] CmdRestore  = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgDebounce    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMinInterval = 1'b1;

  localparam logic [DelayW-1:0] DelayMax         = 12'd3600;
  localparam logic [DelayW-1:0] DelayReset       = 12'd5;
  localparam logic [TimeW-1:0]  DebounceReset    = 32'd3000;
  localparam logic [TimeW-1:0]  MinIntervalReset = 32'd30000;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic signed [31:0] new_delay;
    logic [TimeW-1:0]  now_ms;
    logic              save_ok;
    logic [SeqW-1:0]   restore_seq;
    logic              restore_slot_a;
  } item_t;

  typedef struct packed {
    logic              save_request;
    logic              target_slot_a;
    logic [SeqW-1:0]   target_seq;
    logic [DelayW-1:0] delay_seconds;
    logic              dirty;
  } result_t;

  typedef struct packed {
    logic [TimeW-1:0] debounce_time_ms;
    logic [TimeW-1:0] min_write_interval_ms;
  } cfg_t;

endpackage

/* rtl/dss_if.sv */
// valid/ready channel interfaces for the debounced save scheduler
// depends on dss_pkg
interface dss_in_if;
  logic                       valid;
  logic                       ready;
  logic [dss_pkg::CmdW-1:0]   cmd;
  logic signed [31:0]         new_delay;
  logic [dss_pkg::TimeW-1:0]  now_ms;
  logic                       save_ok;
  logic [dss_pkg::SeqW-1:0]   restore_seq;
  logic                       restore_slot_a;

  modport source (output valid, cmd, new_delay, now_ms, save_ok, restore_seq,
                  restore_slot_a, input ready);
  modport sink   (input valid, cmd, new_delay, now_ms, save_ok, restore_seq,
                  restore_slot_a, output ready);
endinterface

interface dss_out_if;
  logic                        valid;
  logic                        ready;
  logic                        save_request;
  logic                        target_slot_a;
  logic [dss_pkg::SeqW-1:0]    target_seq;
  logic [dss_pkg::DelayW-1:0]  delay_seconds;
  logic                        dirty;

  modport source (output valid, save_request, target_slot_a, target_seq,
                  delay_seconds, dirty, input ready);
  modport sink   (input valid, save_request, target_slot_a, target_seq,
                  delay_seconds, dirty, output ready);
endinterface

interface dss_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dss_pkg::CfgIdxW-1:0]   index;
  logic [dss_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/dss_core.sv */
// scheduler state and per-transaction next-state logic
// depends on dss_pkg
module dss_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  dss_pkg::item_t   item,
  input  dss_pkg::cfg_t    cfg,
  output dss_pkg::result_t res
);

  logic [dss_pkg::DelayW-1:0] delay_r, delay_nxt;
  logic                       dirty_r, dirty_nxt;
  logic [dss_pkg::TimeW-1:0]  change_time_r, change_time_nxt;
  logic [dss_pkg::TimeW-1:0]  save_time_r, save_time_nxt;
  logic [dss_pkg::SeqW-1:0]   seq_r, seq_nxt;
  logic                       slot_a_r, slot_a_nxt;
  logic                       outstanding_r, outstanding_nxt;
  logic                       changed_r, changed_nxt;

  logic [dss_pkg::DelayW-1:0] clamped;
  logic [dss_pkg::TimeW-1:0]  since_change;
  logic [dss_pkg::TimeW-1:0]  since_save;
  logic                       save_due;

  // negative goes to zero, large values saturate
  always_comb begin
    if (item.new_delay[31]) begin
      clamped = '0;
    end else if (item.new_delay > $signed({20'd0, dss_pkg::DelayMax})) begin
      clamped = dss_pkg::DelayMax;
    end else begin
      clamped = item.new_delay[dss_pkg::DelayW-1:0];
    end
  end

  assign since_change = item.now_ms - change_time_r;
  assign since_save   = item.now_ms - save_time_r;
  assign save_due = dirty_r && !outstanding_r &&
                    (since_change >= cfg.debounce_time_ms) &&
                    ((save_time_r == '0) || (since_save >= cfg.min_write_interval_ms));

  always_comb begin
    delay_nxt       = delay_r;
    dirty_nxt       = dirty_r;
    change_time_nxt = change_time_r;
    save_time_nxt   = save_time_r;
    seq_nxt         = seq_r;
    slot_a_nxt      = slot_a_r;
    outstanding_nxt = outstanding_r;
    changed_nxt     = changed_r;
    res.save_request  = 1'b0;
    res.target_slot_a = 1'b0;
    res.target_seq    = '0;
    unique case (item.cmd)
      dss_pkg::CmdSetDelay: begin
        if (clamped != delay_r) begin
          delay_nxt       = clamped;
          dirty_nxt       = 1'b1;
          change_time_nxt = item.now_ms;
          if (outstanding_r) begin
            changed_nxt = 1'b1;
          end
        end
      end
      dss_pkg::CmdTick: begin
        if (save_due) begin
          res.save_request  = 1'b1;
          res.target_slot_a = !slot_a_r;
          res.target_seq    = seq_r + 1'b1;
          outstanding_nxt   = 1'b1;
          changed_nxt       = 1'b0;
          save_time_nxt     = item.now_ms;
        end
      end
      dss_pkg::CmdSaveDone: begin
        // stray completion with nothing outstanding is dropped
        if (outstanding_r) begin
          if (item.save_ok) begin
            seq_nxt    = seq_r + 1'b1;
            slot_a_nxt = !slot_a_r;
            dirty_nxt  = changed_r;
          end
          outstanding_nxt = 1'b0;
          changed_nxt     = 1'b0;
        end
      end
      dss_pkg::CmdRestore: begin
        delay_nxt       = clamped;
        seq_nxt         = item.restore_seq;
        slot_a_nxt      = item.restore_slot_a;
        dirty_nxt       = 1'b0;
        outstanding_nxt = 1'b0;
        changed_nxt     = 1'b0;
      end
      default: begin
      end
    endcase
    res.delay_seconds = delay_nxt;
    res.dirty         = dirty_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r       <= dss_pkg::DelayReset;
      dirty_r       <= 1'b1;
      change_time_r <= '0;
      save_time_r   <= '0;
      seq_r         <= '0;
      slot_a_r      <= 1'b1;
      outstanding_r <= 1'b0;
      changed_r     <= 1'b0;
    end else if (fire) begin
      delay_r       <= delay_nxt;
      dirty_r       <= dirty_nxt;
      change_time_r <= change_time_nxt;
      save_time_r   <= save_time_nxt;
      seq_r         <= seq_nxt;
      slot_a_r      <= slot_a_nxt;
      outstanding_r <= outstanding_nxt;
      changed_r     <= changed_nxt;
    end
  end

  a_changed_needs_save: assert property (@(posedge clk) disable iff (!rst_n)
    changed_r |-> outstanding_r)
    else $error("change-during-save flag set with no save outstanding");

  a_request_opens_save: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.save_request |=> outstanding_r && !changed_r)
    else $error("save request did not open an outstanding save");

  a_no_request_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    outstanding_r |-> !res.save_request)
    else $error("second save requested while one is outstanding");

  a_restore_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.cmd == dss_pkg::CmdRestore) |=> !dirty_r && !outstanding_r)
    else $error("restore left dirty or outstanding state");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(delay_r) && $stable(seq_r) && $stable(dirty_r))
    else $error("scheduler state moved without a transaction");

endmodule

/* rtl/debounced_save_scheduler.sv */
// top level of the debounced save scheduler: input register, config registers,
// scheduler core and result register; depends on dss_pkg, dss_if and dss_core
//
// Takes one command transaction per clock (set_delay, tick, save_done,
// restore) and returns exactly one result transaction for each, in order.
// Throughput is one transaction per cycle when out_if is not stalling. A
// command is held in the input register; the state update is done in the
// single combinational pass as it leaves that register, and the result is
// captured in the result register. Backpressure from out_if.ready stalls
// both stages; in_if.ready stays high while either stage can move. The
// configuration channel is always ready and must only be written while no
// transaction is in flight; register 0 is the debounce time in ms, register
// 1 the minimum save interval in ms. After reset the delay is 5 s, the
// settings count as dirty and nothing has been saved yet.
module debounced_save_scheduler (
  input logic  clk,
  input logic  rst_n,
  dss_in_if.sink    in_if,
  dss_out_if.source out_if,
  dss_cfg_if.sink   cfg_if
);

  // input register stage
  logic             s1_valid_r;
  dss_pkg::item_t   s1_item_r;
  // result register stage
  logic             out_valid_r;
  dss_pkg::result_t out_res_r;
  // config registers
  dss_pkg::cfg_t    cfg_r;

  dss_pkg::result_t res;
  logic             s1_adv;
  logic             in_fire;

  // stage 1 moves when the result register is free or draining
  assign s1_adv  = !out_valid_r || out_if.ready;
  assign in_if.ready = !s1_valid_r || s1_adv;
  assign in_fire = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.cmd            <= in_if.cmd;
      s1_item_r.new_delay      <= in_if.new_delay;
      s1_item_r.now_ms         <= in_if.now_ms;
      s1_item_r.save_ok        <= in_if.save_ok;
      s1_item_r.restore_seq    <= in_if.restore_seq;
      s1_item_r.restore_slot_a <= in_if.restore_slot_a;
    end
  end

  // config write port, never stalls
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time_ms      <= dss_pkg::DebounceReset;
      cfg_r.min_write_interval_ms <= dss_pkg::MinIntervalReset;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        dss_pkg::CfgDebounce:    cfg_r.debounce_time_ms      <= cfg_if.data;
        dss_pkg::CfgMinInterval: cfg_r.min_write_interval_ms <= cfg_if.data;
        default: begin
        end
      endcase
    end
  end

  // state update happens as the item leaves stage 1
  dss_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_valid_r && s1_adv),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.save_request  = out_res_r.save_request;
  assign out_if.target_slot_a = out_res_r.target_slot_a;
  assign out_if.target_seq    = out_res_r.target_seq;
  assign out_if.delay_seconds = out_res_r.delay_seconds;
  assign out_if.dirty         = out_res_r.dirty;

endmodule

/* sim/debounced_save_scheduler_tb.sv */
// self-checking testbench for debounced_save_scheduler: directed and random command
// transactions, checked against an in-bench save scheduling predictor
// depends on rtl/dss_pkg.sv, rtl/dss_if.sv and rtl/debounced_save_scheduler.sv
module debounced_save_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dss_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  dss_in_if  in_if ();
  dss_out_if out_if ();
  dss_cfg_if cfg_if ();

  debounced_save_scheduler DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // commands waiting to be offered, and the result each accepted command should give
  item_t   cmd_backlog[$];
  result_t save_decisions[$];

  int unsigned n_errors     = 0;
  int unsigned n_cmds_taken = 0;

  // idling controls: per-side random waits, plus one long receiver hold-off
  logic        src_idle;
  logic        snk_idle;
  logic        sink_hold;
  int unsigned src_wait  = 0;
  int unsigned sink_wait = 0;
  item_t       on_wire;

  // time base used to build well-formed random sequences
  logic [TimeW-1:0] clock_ms = '0;

  // --------------------------------------------------------------------------
  // scheduler predictor: its own copy of the registers and the save state
  // --------------------------------------------------------------------------
  logic [TimeW-1:0]  cfg_debounce_ms = DebounceReset;
  logic [TimeW-1:0]  cfg_min_gap_ms  = MinIntervalReset;

  logic [DelayW-1:0] sched_delay       = DelayReset;
  logic              sched_dirty       = 1'b1;   // defaults never saved
  logic [TimeW-1:0]  sched_change_ms   = '0;
  logic [TimeW-1:0]  sched_save_ms     = '0;     // zero reads as never saved
  logic [SeqW-1:0]   sched_seq         = '0;
  logic              sched_slot_a      = 1'b1;
  logic              sched_busy        = 1'b0;   // a save request is outstanding
  logic              sched_changed_mid = 1'b0;   // value changed while busy

  // negative requests go to zero, large ones saturate at the maximum
  function automatic logic [DelayW-1:0] clamp_seconds(input logic signed [31:0] raw);
    if (raw < 0) return '0;
    if (raw > int'(DelayMax)) return DelayMax;
    return raw[DelayW-1:0];
  endfunction

  task automatic schedule_step(input item_t cmd_in, output result_t res);
    logic [DelayW-1:0] secs;
    logic [TimeW-1:0]  since_change;
    logic [TimeW-1:0]  since_save;
    res          = '0;
    secs         = clamp_seconds(cmd_in.new_delay);
    since_change = cmd_in.now_ms - sched_change_ms;   // modulo 2^32
    since_save   = cmd_in.now_ms - sched_save_ms;
    case (cmd_in.cmd)
      CmdSetDelay: begin
        // only a real change marks the settings dirty
        if (secs != sched_delay) begin
          sched_delay     = secs;
          sched_dirty     = 1'b1;
          sched_change_ms = cmd_in.now_ms;
          if (sched_busy) sched_changed_mid = 1'b1;
        end
      end
      CmdTick: begin
        if (sched_dirty && !sched_busy && since_change >= cfg_debounce_ms &&
            (sched_save_ms == '0 || since_save >= cfg_min_gap_ms)) begin
          res.save_request  = 1'b1;
          res.target_slot_a = !sched_slot_a;
          res.target_seq    = sched_seq + 1'b1;
          sched_busy        = 1'b1;
          sched_changed_mid = 1'b0;
          sched_save_ms     = cmd_in.now_ms;
        end
      end
      CmdSaveDone: begin
        // a save_done with nothing outstanding is dropped
        if (sched_busy) begin
          if (cmd_in.save_ok) begin
            sched_seq    = sched_seq + 1'b1;
            sched_slot_a = !sched_slot_a;
            sched_dirty  = sched_changed_mid;
          end
          sched_busy        = 1'b0;
          sched_changed_mid = 1'b0;
        end
      end
      CmdRestore: begin
        // load from storage, abandon any save in progress, keep both times
        sched_delay       = secs;
        sched_seq         = cmd_in.restore_seq;
        sched_slot_a      = cmd_in.restore_slot_a;
        sched_dirty       = 1'b0;
        sched_busy        = 1'b0;
        sched_changed_mid = 1'b0;
      end
      default: ;
    endcase
    res.delay_seconds = sched_delay;
    res.dirty         = sched_dirty;
  endtask

  // --------------------------------------------------------------------------
  // driver: offers commands from the backlog, predicts each accepted one
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_cmds
    result_t predicted;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        schedule_step(on_wire, predicted);
        save_decisions.push_back(predicted);
        n_cmds_taken++;
        src_wait = src_idle ? $urandom_range(0, 7) : 0;
      end
      // the channel is free once nothing is held or the held transaction just went
      if (!in_if.valid || in_if.ready) begin
        if (src_wait != 0) begin
          src_wait--;
          in_if.valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          on_wire                = cmd_backlog.pop_front();
          in_if.valid            <= 1'b1;
          in_if.cmd              <= on_wire.cmd;
          in_if.new_delay        <= on_wire.new_delay;
          in_if.now_ms           <= on_wire.now_ms;
          in_if.save_ok          <= on_wire.save_ok;
          in_if.restore_seq      <= on_wire.restore_seq;
          in_if.restore_slot_a   <= on_wire.restore_slot_a;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks every result transaction against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (save_decisions.size() == 0) begin
          $error("result transaction with no command outstanding");
          n_errors++;
        end else begin
          want = save_decisions.pop_front();
          check_field("save_request",  32'(want.save_request),  32'(out_if.save_request));
          check_field("target_slot_a", 32'(want.target_slot_a), 32'(out_if.target_slot_a));
          check_field("target_seq",    want.target_seq,         out_if.target_seq);
          check_field("delay_seconds", 32'(want.delay_seconds), 32'(out_if.delay_seconds));
          check_field("dirty",         32'(want.dirty),         32'(out_if.dirty));
        end
        sink_wait = snk_idle ? $urandom_range(0, 7) : 0;
      end else if (sink_wait != 0) begin
        sink_wait--;
      end
      out_if.ready <= !sink_hold && (sink_wait == 0);
    end
  end

  // long receiver hold-off while the sender keeps offering, so both stages fill
  initial begin : long_stall
    sink_hold = 1'b0;
    while (n_cmds_taken < 300) @(posedge clk);
    sink_hold <= 1'b1;
    repeat (250) @(posedge clk);
    sink_hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_cmd(input logic [CmdW-1:0] cmd, input logic signed [31:0] secs,
                          input logic [TimeW-1:0] now, input logic ok,
                          input logic [SeqW-1:0] seq, input logic slot_a);
    item_t cmd_in;
    cmd_in.cmd            = cmd;
    cmd_in.new_delay      = secs;
    cmd_in.now_ms         = now;
    cmd_in.save_ok        = ok;
    cmd_in.restore_seq    = seq;
    cmd_in.restore_slot_a = slot_a;
    cmd_backlog.push_back(cmd_in);
  endtask

  // every field random, including the ones the command does not use
  function automatic item_t rand_cmd();
    item_t cmd_in;
    cmd_in.cmd            = CmdW'($urandom_range(0, 3));
    cmd_in.new_delay      = $urandom;
    cmd_in.now_ms         = $urandom;
    cmd_in.save_ok        = 1'($urandom_range(0, 1));
    cmd_in.restore_seq    = $urandom;
    cmd_in.restore_slot_a = 1'($urandom_range(0, 1));
    return cmd_in;
  endfunction

  // small values in a third of picks so repeats (no change) are common
  function automatic logic signed [31:0] pick_delay();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom_range(0, 6);
      2:       return $urandom_range(3590, 3610);
      3:       return 32'h8000_0000 | $urandom;
      default: return $urandom;
    endcase
  endfunction

  // wait until the block holds nothing, then let its two stages settle;
  // checked on the falling edge so the driver's updates have all landed
  task automatic settle();
    @(negedge clk);
    while (cmd_backlog.size() != 0 || in_if.valid || save_decisions.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both registers in one burst; valid stays high across the two transactions
  task automatic write_limits(input logic [TimeW-1:0] debounce,
                              input logic [TimeW-1:0] min_gap);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CfgDebounce;
    cfg_if.data  <= debounce;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_debounce_ms = debounce;
    cfg_if.index <= CfgMinInterval;
    cfg_if.data  <= min_gap;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_min_gap_ms = min_gap;
    cfg_if.valid <= 1'b0;
  endtask

  // mostly edit / tick / save outcome sequences on a running clock, some noise
  task automatic run_random(input int n, input logic [TimeW-1:0] step_max);
    item_t cmd_in;
    int    made;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 4) != 0) begin
        repeat ($urandom_range(1, 3)) begin
          cmd_in           = rand_cmd();
          cmd_in.cmd       = CmdSetDelay;
          cmd_in.new_delay = pick_delay();
          clock_ms        += $urandom_range(0, step_max);
          cmd_in.now_ms    = clock_ms;
          cmd_backlog.push_back(cmd_in);
          made++;
        end
        repeat ($urandom_range(1, 4)) begin
          cmd_in        = rand_cmd();
          cmd_in.cmd    = CmdTick;
          clock_ms     += $urandom_range(0, step_max);
          cmd_in.now_ms = clock_ms;
          cmd_backlog.push_back(cmd_in);
          made++;
        end
        cmd_in         = rand_cmd();
        cmd_in.cmd     = CmdSaveDone;
        cmd_in.save_ok = ($urandom_range(0, 3) != 0);
        clock_ms      += $urandom_range(0, step_max);
        cmd_in.now_ms  = clock_ms;
        cmd_backlog.push_back(cmd_in);
        made++;
      end else begin
        // noise: any command, sometimes a jump in time, extreme stored sequences
        cmd_in = rand_cmd();
        if ($urandom_range(0, 1) != 0) cmd_in.now_ms = clock_ms;
        if (cmd_in.cmd == CmdRestore && $urandom_range(0, 1) != 0)
          cmd_in.restore_seq = ($urandom_range(0, 1) != 0) ? '1 : '0;
        clock_ms = cmd_in.now_ms;
        cmd_backlog.push_back(cmd_in);
        made++;
      end
    end
    while (cmd_backlog.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.cmd            = CmdTick;
    in_if.new_delay      = '0;
    in_if.now_ms         = '0;
    in_if.save_ok        = 1'b0;
    in_if.restore_seq    = '0;
    in_if.restore_slot_a = 1'b0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = CfgDebounce;
    cfg_if.data          = '0;
    src_idle             = 1'b1;
    snk_idle             = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset limits: debounce 3000, min interval 30000
    push_cmd(CmdTick,     0,            0,      0, 0, 0);  // dirty but not debounced
    push_cmd(CmdTick,     0,            3000,   0, 0, 0);  // first save, slot B seq 1
    push_cmd(CmdTick,     0,            3001,   0, 0, 0);  // busy, no new request
    push_cmd(CmdSetDelay, 100,          4000,   0, 0, 0);  // change during the save
    push_cmd(CmdSaveDone, 0,            4100,   1, 0, 0);  // commit, dirty stays set
    push_cmd(CmdTick,     0,            8000,   0, 0, 0);  // interval not yet passed
    push_cmd(CmdTick,     0,            33000,  0, 0, 0);  // save to slot A seq 2
    push_cmd(CmdSaveDone, 0,            33100,  0, 0, 0);  // failed write
    push_cmd(CmdTick,     0,            40000,  0, 0, 0);  // failed attempt still counts
    push_cmd(CmdTick,     0,            63000,  0, 0, 0);  // retry
    push_cmd(CmdSaveDone, 0,            63100,  1, 0, 0);  // clean now
    push_cmd(CmdSetDelay, -1,           70000,  0, 0, 0);  // negative clamps to zero
    push_cmd(CmdSetDelay, 32'h7fffffff, 70100,  0, 0, 0);  // saturates at 3600
    push_cmd(CmdSetDelay, 3601,         70200,  0, 0, 0);  // clamps to same value
    push_cmd(CmdSetDelay, 32'h80000000, 70300,  0, 0, 0);  // most negative
    push_cmd(CmdRestore,  4000,         80000,  0, '1, 0); // restore, top sequence
    push_cmd(CmdSetDelay, 7,            100000, 0, 0, 0);
    push_cmd(CmdTick,     0,            103000, 0, 0, 0);  // sequence wraps to 0
    push_cmd(CmdRestore,  -5,           103500, 1, 10, 1); // abandons the save
    push_cmd(CmdSaveDone, 0,            103600, 1, 0, 0);  // stray, ignored
    push_cmd(CmdSetDelay, 9,            32'hfffffed8, 0, 0, 0);
    push_cmd(CmdTick,     0,            2000,   0, 0, 0);  // time wrapped, not debounced
    push_cmd(CmdTick,     0,            3000,   0, 0, 0);  // debounced across the wrap
    settle();

    // zero limits: a request at time zero leaves the block as never saved
    write_limits('0, '0);
    push_cmd(CmdSaveDone, 0,    10, 1, 0, 0);
    push_cmd(CmdSetDelay, 1234, 0,  0, 0, 0);
    push_cmd(CmdTick,     0,    0,  0, 0, 0);
    push_cmd(CmdSaveDone, 0,    0,  0, 0, 0);
    settle();
    write_limits('0, '1);
    push_cmd(CmdTick,     0, 12345, 0, 0, 0);              // allowed: never saved
    push_cmd(CmdSaveDone, 0, 12400, 1, 0, 0);
    settle();

    // random phases over several limit settings and idling mixes
    write_limits(32'd100, 32'd500);
    run_random(400, 200);
    settle();

    src_idle = 1'b0;
    snk_idle = 1'b0;
    write_limits('0, '0);
    run_random(200, 50);
    settle();

    src_idle = 1'b1;
    write_limits('1, '1);
    run_random(100, 1000);
    settle();

    src_idle = 1'b0;
    snk_idle = 1'b1;
    write_limits($urandom_range(0, 2000), $urandom_range(0, 8000));
    run_random(300, 1000);
    settle();

    src_idle = 1'b1;
    write_limits(DebounceReset, MinIntervalReset);
    run_random(300, 8000);
    settle();

    src_idle = 1'b0;
    snk_idle = 1'b0;
    write_limits($urandom, $urandom);
    run_random(100, '1);
    settle();

    src_idle = 1'b1;
    snk_idle = 1'b1;
    write_limits(32'd100, 32'd500);
    run_random(200, 200);
    settle();

    if (n_errors == 0 && save_decisions.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
rtl/dss_pkg.sv
rtl/dss_if.sv
rtl/dss_core.sv
rtl/debounced_save_scheduler.sv
sim/debounced_save_scheduler_tb.sv
